// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the framer RTL; expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent at an edge implies consequent at the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/nlf_pkg.sv -----
// Types and constants shared by the framer modules.
`default_nettype none
package nlf_pkg;

  localparam int unsigned LEN_W = 6;
  localparam logic [7:0] DELIM_RESET = 8'd10;
  localparam int unsigned OUT_DEPTH = 4;

  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
    logic             ovf;
  } desc_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [LEN_W-1:0] idx;
    logic [7:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       ovf;
    logic       last;
  } out_word_t;

endpackage
`default_nettype wire

// ----- rtl/nlf_front.sv -----
// Front end: accepts input words, tracks the segment fill and posts frame descriptors.
`default_nettype none
`include "assert_macros.svh"
module nlf_front #(
  parameter int unsigned MAX_SEG = 62
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            end_of_line_i,
  input  wire logic [7:0]      delim_i,
  input  wire logic            desc_full_i,
  output nlf_pkg::mem_wr_t     mem_wr_o,
  output logic                 desc_push_o,
  output nlf_pkg::desc_t       desc_o
);

  logic [nlf_pkg::LEN_W-1:0] fill_q, fill_d;
  logic                      ovf_q, ovf_d;
  logic                      bank_q, bank_d;

  always_comb begin
    fill_d        = fill_q;
    ovf_d         = ovf_q;
    bank_d        = bank_q;
    mem_wr_o.en   = 1'b0;
    mem_wr_o.bank = bank_q;
    mem_wr_o.idx  = fill_q;
    mem_wr_o.data = in_byte_i;
    desc_push_o   = 1'b0;
    desc_o.bank   = bank_q;
    desc_o.len    = fill_q;
    desc_o.ovf    = ovf_q;
    if (accept_i) begin
      if (in_byte_i == delim_i) begin
        desc_push_o = 1'b1;
        fill_d      = '0;
        ovf_d       = 1'b0;
        bank_d      = ~bank_q;
      end else begin
        if (fill_q < nlf_pkg::LEN_W'(MAX_SEG)) begin
          mem_wr_o.en = 1'b1;
          fill_d      = fill_q + nlf_pkg::LEN_W'(1);
        end else begin
          ovf_d = 1'b1;
        end
        // a non-delimiter word always leaves a non-empty segment
        if (end_of_line_i) begin
          desc_push_o = 1'b1;
          desc_o.len  = fill_d;
          desc_o.ovf  = ovf_d;
          bank_d      = ~bank_q;
        end
      end
      if (end_of_line_i) begin
        fill_d = '0;
        ovf_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
      bank_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
      bank_q <= bank_d;
    end
  end

  `ASSERT_ALWAYS(a_fill_bound, fill_q <= nlf_pkg::LEN_W'(MAX_SEG), "fill beyond segment size")
  `ASSERT_IMPLIES(a_push_room, desc_push_o, !desc_full_i, "descriptor push into full queue")
  `ASSERT_IMPLIES(a_wr_room, mem_wr_o.en, !desc_full_i, "buffer write while both banks busy")

endmodule
`default_nettype wire

// ----- rtl/nlf_desc_queue.sv -----
// Two-entry queue of frame descriptors between front and back.
`default_nettype none
`include "assert_macros.svh"
module nlf_desc_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire nlf_pkg::desc_t  desc_i,
  input  wire logic            pop_i,
  output nlf_pkg::desc_t       desc_o,
  output logic                 valid_o,
  output logic                 full_o
);

  nlf_pkg::desc_t ent_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;

  assign desc_o  = ent_q[rd_ptr_q];
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  `ASSERT_IMPLIES(a_no_underflow, pop_i, valid_o, "descriptor pop from empty queue")
  `ASSERT_IMPLIES(a_no_overflow, push_i, !full_o, "descriptor push into full queue")
  `ASSERT_ALWAYS(a_cnt_bound, cnt_q <= 2'd2, "descriptor count out of range")

endmodule
`default_nettype wire

// ----- rtl/nlf_back.sv -----
// Back end: segment buffer, frame sequencer and output word queue.
`default_nettype none
`include "assert_macros.svh"
module nlf_back #(
  parameter int unsigned MAX_SEG = 62
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire nlf_pkg::mem_wr_t  mem_wr_i,
  input  wire nlf_pkg::desc_t    desc_i,
  input  wire logic              desc_valid_i,
  output logic                   desc_pop_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output nlf_pkg::out_word_t     word_o
);

  localparam int unsigned DEPTH = 2 * MAX_SEG;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OPW   = $clog2(nlf_pkg::OUT_DEPTH);
  localparam int unsigned OCW   = $clog2(nlf_pkg::OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HDR_HI,
    PH_HDR_LO,
    PH_DATA
  } phase_e;

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  phase_e                    phase_q;
  logic [nlf_pkg::LEN_W-1:0] idx_q;
  logic                      s1_valid_q, s1_mem_q;
  nlf_pkg::out_word_t        s1_word_q;

  nlf_pkg::out_word_t oq_q [nlf_pkg::OUT_DEPTH];
  logic [OPW-1:0]     oq_wr_q, oq_rd_q;
  logic [OCW-1:0]     oq_cnt_q;

  logic               issue;
  logic               data_last;
  logic [15:0]        len16;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic               oq_pop;
  nlf_pkg::out_word_t push_word;

  assign wr_addr = mem_wr_i.bank ? AW'(MAX_SEG) + AW'(mem_wr_i.idx) : AW'(mem_wr_i.idx);
  assign rd_addr = desc_i.bank ? AW'(MAX_SEG) + AW'(idx_q) : AW'(idx_q);

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      mem_q[wr_addr] <= mem_wr_i.data;
    end
    if (issue && phase_q == PH_DATA) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign len16     = 16'(desc_i.len);
  assign data_last = (idx_q == desc_i.len - nlf_pkg::LEN_W'(1));
  assign issue     = desc_valid_i &&
                     ((oq_cnt_q + OCW'(s1_valid_q)) < OCW'(nlf_pkg::OUT_DEPTH));

  always_comb begin
    desc_pop_o = 1'b0;
    if (issue) begin
      case (phase_q)
        PH_HDR_LO: desc_pop_o = (desc_i.len == '0);
        PH_DATA:   desc_pop_o = data_last;
        default:   desc_pop_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR_HI;
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_mem_q   <= 1'b0;
      s1_word_q  <= '0;
    end else begin
      s1_valid_q <= issue;
      if (issue) begin
        s1_word_q.ovf <= desc_i.ovf;
        case (phase_q)
          PH_HDR_HI: begin
            s1_mem_q        <= 1'b0;
            s1_word_q.data  <= len16[15:8];
            s1_word_q.hdr   <= 1'b1;
            s1_word_q.last  <= 1'b0;
            phase_q         <= PH_HDR_LO;
          end
          PH_HDR_LO: begin
            s1_mem_q        <= 1'b0;
            s1_word_q.data  <= len16[7:0];
            s1_word_q.hdr   <= 1'b1;
            s1_word_q.last  <= (desc_i.len == '0);
            idx_q           <= '0;
            phase_q         <= (desc_i.len == '0) ? PH_HDR_HI : PH_DATA;
          end
          PH_DATA: begin
            s1_mem_q        <= 1'b1;
            s1_word_q.data  <= '0;
            s1_word_q.hdr   <= 1'b0;
            s1_word_q.last  <= data_last;
            idx_q           <= idx_q + nlf_pkg::LEN_W'(1);
            phase_q         <= data_last ? PH_HDR_HI : PH_DATA;
          end
          default: begin
            phase_q <= PH_HDR_HI;
          end
        endcase
      end
    end
  end

  always_comb begin
    push_word = s1_word_q;
    if (s1_mem_q) begin
      push_word.data = rdata_q;
    end
  end

  assign empty_o = (oq_cnt_q == '0);
  assign word_o  = oq_q[oq_rd_q];
  assign oq_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      oq_q[oq_wr_q] <= push_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (s1_valid_q) begin
        oq_wr_q <= oq_wr_q + OPW'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + OPW'(1);
      end
      oq_cnt_q <= oq_cnt_q + OCW'(s1_valid_q) - OCW'(oq_pop);
    end
  end

  `ASSERT_ALWAYS(a_oq_bound, oq_cnt_q <= OCW'(nlf_pkg::OUT_DEPTH), "output queue overrun")
  `ASSERT_IMPLIES(a_oq_room, s1_valid_q, oq_cnt_q < OCW'(nlf_pkg::OUT_DEPTH), "word arrives at full output queue")
  `ASSERT_IMPLIES(a_data_desc, phase_q == PH_DATA, desc_valid_i, "payload phase without frame")

endmodule
`default_nettype wire

// ----- rtl/newline_to_length_prefix_framer.sv -----
// Top level: delimiter register, front end, descriptor queue and back end.
// Accepts one input word per cycle while full is low; full rises only while two frames
// wait in the back end. A frame of L payload bytes leaves as L+2 words, one per cycle
// while the output queue has room; the header passes the s1 stage and the output queue.
// rst_ni clears control state at once; the delimiter resets to newline, buffer is not cleared.
`default_nettype none
module newline_to_length_prefix_framer #(
  parameter int unsigned MAX_SEG = 62
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        end_of_line_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte_o,
  output logic             is_header_o,
  output logic             overflow_o,
  output logic             frame_end_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0]         delim_q;
  logic               accept;
  nlf_pkg::mem_wr_t   mem_wr;
  logic               desc_push, desc_pop, desc_valid;
  nlf_pkg::desc_t     desc_in, desc_head;
  nlf_pkg::out_word_t word;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {24'd0, delim_q};
  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= nlf_pkg::DELIM_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      delim_q <= pwdata[7:0];
    end
  end

  nlf_front #(.MAX_SEG(MAX_SEG)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_byte_i),
    .end_of_line_i (end_of_line_i),
    .delim_i       (delim_q),
    .desc_full_i   (full),
    .mem_wr_o      (mem_wr),
    .desc_push_o   (desc_push),
    .desc_o        (desc_in)
  );

  nlf_desc_queue u_desc_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .desc_i  (desc_in),
    .pop_i   (desc_pop),
    .desc_o  (desc_head),
    .valid_o (desc_valid),
    .full_o  (full)
  );

  nlf_back #(.MAX_SEG(MAX_SEG)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mem_wr_i     (mem_wr),
    .desc_i       (desc_head),
    .desc_valid_i (desc_valid),
    .desc_pop_o   (desc_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .word_o       (word)
  );

  assign out_byte_o  = word.data;
  assign is_header_o = word.hdr;
  assign overflow_o  = word.ovf;
  assign frame_end_o = word.last;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for newline_to_length_prefix_framer: directed table, random lines, scoreboard.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_SEG = 62;
  localparam logic [2:0] DELIM_ADDR = 3'd0;
  localparam int RX_HOLD = 400;
  localparam int SETTLE = 12;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_ITEMS = 16;
  localparam int RAND_PER_PHASE = 4;

  typedef struct {
    logic [7:0] b;
    logic       eol;
    int         rep;
    bit         typed;
    int         hlen;
    bit         hovf;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  in_byte_i;
  logic        end_of_line_i;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte_o;
  logic        is_header_o;
  logic        overflow_o;
  logic        frame_end_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  newline_to_length_prefix_framer #(
    .MAX_SEG(MAX_SEG)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .in_byte_i(in_byte_i),
    .end_of_line_i(end_of_line_i),
    .empty(empty),
    .pop(pop),
    .out_byte_o(out_byte_o),
    .is_header_o(is_header_o),
    .overflow_o(overflow_o),
    .frame_end_o(frame_end_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // predictor state
  logic [7:0] seg_buf [MAX_SEG];
  int         seg_fill;
  bit         seg_ovf;
  logic [7:0] delim_q;

  nlf_pkg::out_word_t frame_words [$];
  nlf_pkg::out_word_t pending_words [$];

  int  errors;
  int  cycles;
  int  tx_calm;
  int  rx_calm;
  bit  rx_hold_req;
  int  sent_items;

  // zero-length frame, delimiter with end of line, overflow and edge bytes
  dir_row_t dir_rows [17] = '{
    '{8'h0A, 1'b0, 1, 1'b1, 0, 1'b0},
    '{8'h0A, 1'b1, 1, 1'b1, 0, 1'b0},
    '{8'h00, 1'b0, 1, 1'b1, -1, 1'b0},
    '{8'hFF, 1'b0, 1, 1'b1, -1, 1'b0},
    '{8'h41, 1'b0, 1, 1'b0, 0, 1'b0},
    '{8'h0A, 1'b0, 1, 1'b1, 3, 1'b0},
    '{8'h80, 1'b1, 1, 1'b1, 1, 1'b0},
    '{8'h55, 1'b0, 1, 1'b0, 0, 1'b0},
    '{8'h0A, 1'b1, 1, 1'b1, 1, 1'b0},
    '{8'h0A, 1'b0, 1, 1'b1, 0, 1'b0},
    '{8'h0A, 1'b0, 1, 1'b1, 0, 1'b0},
    '{8'h7F, 1'b1, 1, 1'b1, 1, 1'b0},
    '{8'h33, 1'b0, 63, 1'b0, 0, 1'b0},
    '{8'h0A, 1'b0, 1, 1'b1, 62, 1'b1},
    '{8'h0B, 1'b0, 1, 1'b0, 0, 1'b0},
    '{8'h09, 1'b1, 1, 1'b1, 2, 1'b0},
    '{8'hC3, 1'b1, 1, 1'b1, 1, 1'b0}
  };

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("newline_to_length_prefix_framer verification failed");
    $finish;
  end

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    errors++;
    if (errors <= 40)
      $display("mismatch %s: expected 0x%0h got 0x%0h at %0t", field, want, got, $time);
  endtask

  function automatic int next_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 5) == 0) begin
      calm = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  task automatic close_segment();
    int len;
    len = (seg_fill > MAX_SEG) ? MAX_SEG : seg_fill;
    frame_words.push_back('{8'((len >> 8) & 8'hFF), 1'b1, seg_ovf, 1'b0});
    frame_words.push_back('{8'(len & 8'hFF), 1'b1, seg_ovf, len == 0});
    for (int i = 0; i < len; i++)
      frame_words.push_back('{seg_buf[i], 1'b0, seg_ovf, i + 1 == len});
    seg_fill = 0;
    seg_ovf = 1'b0;
  endtask

  task automatic predict_framing(input logic [7:0] b, input logic eol);
    frame_words.delete();
    if (b == delim_q) begin
      close_segment();
    end else begin
      if (seg_fill < MAX_SEG) begin
        seg_buf[seg_fill] = b;
        seg_fill++;
      end else begin
        seg_ovf = 1'b1;
      end
      if (eol && seg_fill > 0) close_segment();
    end
    if (eol) begin
      seg_fill = 0;
      seg_ovf = 1'b0;
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic eol, input bit typed,
                           input int hlen, input bit hovf);
    int gap;
    nlf_pkg::out_word_t got [$];
    nlf_pkg::out_word_t w;
    gap = next_gap(tx_calm);
    repeat (gap) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push <= 1'b1;
    in_byte_i <= b;
    end_of_line_i <= eol;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_items++;
    predict_framing(b, eol);
    if (typed) begin
      got = frame_words;
      frame_words.delete();
      if (hlen >= 0) begin
        frame_words.push_back('{8'h00, 1'b1, hovf, 1'b0});
        frame_words.push_back('{8'(hlen), 1'b1, hovf, hlen == 0});
        for (int i = 2; i < got.size(); i++) begin
          w = got[i];
          w.ovf = hovf;
          frame_words.push_back(w);
        end
      end
    end
    foreach (frame_words[i]) pending_words.push_back(frame_words[i]);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_delim(input logic [7:0] v);
    wait_drained();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DELIM_ADDR;
    pwdata <= {24'h0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    delim_q = v;
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {24'h0, v}) report_mismatch("prdata", {24'h0, v}, prdata);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == delim_q) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send_random_line();
    int n_seg;
    int len;
    int r;
    bit last;
    bit end_on_data;
    logic [7:0] b;
    n_seg = $urandom_range(1, 3);
    for (int s = 0; s < n_seg; s++) begin
      last = (s == n_seg - 1);
      r = $urandom_range(0, 11);
      if (r == 0) len = $urandom_range(9, 16);
      else if (r < 3) len = 0;
      else len = $urandom_range(1, 8);
      end_on_data = last && len > 0 && $urandom_range(0, 1);
      for (int k = 0; k < len; k++) begin
        b = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255)) : plain_byte();
        send_word(b, end_on_data && k == len - 1, 1'b0, 0, 1'b0);
      end
      if (!end_on_data) send_word(delim_q, last, 1'b0, 0, 1'b0);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n)
      send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, 0, 1'b0);
  endtask

  task automatic run_random_phase(input int count, input bit hold_rx, input bit pause_tx);
    int target;
    target = sent_items + count;
    if (hold_rx) rx_hold_req = 1'b1;
    while (sent_items < target) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      send_random_line();
      if (pause_tx && sent_items >= target - count / 2) begin
        wait_drained();
        pause_tx = 1'b0;
      end
    end
  endtask

  initial begin : drain_results
    nlf_pkg::out_word_t want;
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold_req) begin
        @(negedge clk_i);
        pop <= 1'b0;
        repeat (RX_HOLD) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end
      gap = next_gap(rx_calm);
      repeat (gap) begin
        @(negedge clk_i);
        pop <= 1'b0;
      end
      @(negedge clk_i);
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", 0, out_byte_o);
      end else begin
        want = pending_words.pop_front();
        if (out_byte_o !== want.data) report_mismatch("out_byte", want.data, out_byte_o);
        if (is_header_o !== want.hdr) report_mismatch("is_header", want.hdr, is_header_o);
        if (overflow_o !== want.ovf) report_mismatch("overflow", want.ovf, overflow_o);
        if (frame_end_o !== want.last) report_mismatch("frame_end", want.last, frame_end_o);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] phase_delims [2];
    rst_ni = 1'b0;
    push = 1'b0;
    in_byte_i = 8'h00;
    end_of_line_i = 1'b0;
    pop = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = DELIM_ADDR;
    pwdata = 32'h0;
    errors = 0;
    tx_calm = 0;
    rx_calm = 0;
    rx_hold_req = 1'b0;
    sent_items = 0;
    seg_fill = 0;
    seg_ovf = 1'b0;
    delim_q = nlf_pkg::DELIM_RESET;
    phase_delims[0] = 8'h00;
    phase_delims[1] = 8'hFF;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      for (int k = 0; k < dir_rows[i].rep; k++)
        send_word(dir_rows[i].b, dir_rows[i].eol, dir_rows[i].typed,
                  dir_rows[i].hlen, dir_rows[i].hovf);

    run_random_phase(HOLD_ITEMS, 1'b1, 1'b0);
    foreach (phase_delims[p]) begin
      write_delim(phase_delims[p]);
      run_random_phase(RAND_PER_PHASE, 1'b0, p == 0);
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (errors == 0)
      $display("newline_to_length_prefix_framer verification clean");
    else
      $display("newline_to_length_prefix_framer verification failed");
    $finish;
  end

endmodule
